// File: src/pbbr_pkg.sv
// Shared types, codes and constants for the pressure regulator register block.
// Holds the register-file reset table; no dependencies.
package pbbr_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DEF_TABLE_LEN = 32;

    localparam logic [2:0] ACT_WRITE_ADDR = 3'd0;
    localparam logic [2:0] ACT_WRITE_DATA = 3'd1;
    localparam logic [2:0] ACT_READ_FIRST = 3'd2;
    localparam logic [2:0] ACT_READ_NEXT  = 3'd3;
    localparam logic [2:0] ACT_TICK       = 3'd4;

    localparam logic [1:0] ST_RELEASE = 2'd0;
    localparam logic [1:0] ST_HOLD    = 2'd1;
    localparam logic [1:0] ST_INFLATE = 2'd2;

    localparam logic [7:0] MODE_AUTO   = 8'd0;
    localparam logic [7:0] MODE_MANUAL = 8'd1;

    localparam logic [7:0] CTL_BASE        = 8'd16;
    localparam logic [7:0] IDX_PRESSURE_HI = 8'd19;

    localparam logic [2:0] CTL_SETPOINT  = 3'd0;
    localparam logic [2:0] CTL_DESIRED   = 3'd2;
    localparam logic [2:0] CTL_PRESS_HI  = 3'd3;
    localparam logic [2:0] CTL_PRESS_LO  = 3'd4;
    localparam logic [2:0] CTL_HALF_BAND = 3'd5;
    localparam logic [2:0] CTL_MODE      = 3'd6;
    localparam logic [2:0] CTL_PONLY     = 3'd7;

    localparam logic [7:0] DEF_TABLE [DEF_TABLE_LEN] = '{
        8'hFF, 8'hEE, 8'hDD, 8'hCC, 8'hBB, 8'hAA, 8'h99, 8'h88,
        8'h77, 8'h66, 8'h55, 8'h44, 8'h33, 8'h22, 8'h11, 8'hFA,
        8'd127, 8'hEA, 8'd1, 8'hCA, 8'hBA, 8'd10, 8'd1, 8'd1,
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08
    };

    typedef struct packed {
        logic [7:0] setpoint;
        logic [7:0] half_band;
        logic [7:0] mode;
        logic [7:0] desired;
        logic [7:0] pressure;
    } t_ctl_in;

    typedef struct packed {
        logic [1:0] state;
        logic       release_drv;
        logic       inflate_drv;
    } t_valve;

    function automatic logic [7:0] def_entry(input logic [7:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if (idx < 8'(DEF_TABLE_LEN)) begin
            v = DEF_TABLE[idx[4:0]];
        end
        return v;
    endfunction

    function automatic t_valve drive(input logic [1:0] st);
        t_valve v;
        v.state = st;
        v.release_drv = (st == ST_RELEASE);
        v.inflate_drv = (st == ST_INFLATE);
        return v;
    endfunction

endpackage

// File: src/pressure_bang_bang_regulator_regs_top.sv
// Top level of the pressure regulator: bus register file plus valve controller.
// Depends on pbbr_pkg and pbbr_valve.
//
// The block accepts one word per clock while o_ready is high and returns one result word
// for each; each result passes through the registered read port of the register-file
// memory and then the output register, which also lets a new word enter while a result
// waits. Entries 16 to 23 (setpoint, desired state, pressure bytes, half band, mode and
// pressure-only flag) live in flip-flops so that a tick can use them at once; the other
// entries are a memory with one valid bit per entry, so an entry never written reads its
// reset default and no clearing pass is needed after reset.
module pressure_bang_bang_regulator_regs_top #(
    parameter int REGISTER_COUNT = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [2:0]                       i_action,
    input  logic [7:0]                       i_data_byte,
    input  logic [pbbr_pkg::SAMPLE_BITS-1:0] i_pressure_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_read_data,
    output logic                             o_read_valid,
    output logic                             o_release_valve,
    output logic                             o_inflate_valve,
    output logic [1:0]                       o_valve_state
);
    import pbbr_pkg::*;

    localparam int IW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    logic [7:0]          r_ptr;
    logic [7:0]          n_ptr;
    logic                r_expect;
    logic                n_expect;
    t_valve              r_valve;
    t_valve              n_valve;
    t_valve              valve_tick;
    logic [7:0]          r_ctl [8];
    logic [REGISTER_COUNT-1:0] r_vld;
    logic [7:0]          r_mem [REGISTER_COUNT];
    logic [7:0]          r_mem_q;

    logic                r_s1_valid;
    logic                r_s1_rv;
    logic                r_s1_sel_mem;
    logic [7:0]          r_s1_byte;
    t_valve              r_s1_valve;
    logic                n_s1_sel_mem;
    logic [7:0]          n_s1_byte;

    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_rv;
    t_valve              r_out_valve;

    logic                acc;
    logic                s1_move;
    logic                is_rd;
    logic                is_tick;
    logic                do_wr;
    logic                win_w;
    logic                win_r;
    logic                rd_rng;
    logic [7:0]          rp;
    logic [7:0]          p_hi;
    logic [7:0]          p_lo;
    t_ctl_in             ctl;

    assign s1_move = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_move;
    assign acc     = i_valid && o_ready;

    assign is_rd   = (i_action == ACT_READ_FIRST) || (i_action == ACT_READ_NEXT);
    assign is_tick = (i_action == ACT_TICK);
    assign rp      = ((i_action == ACT_READ_FIRST) && (r_ctl[CTL_PONLY] != 8'h00))
                     ? IDX_PRESSURE_HI : r_ptr;
    assign rd_rng  = {1'b0, rp} < 9'(REGISTER_COUNT);
    assign win_r   = (rp[7:3] == CTL_BASE[7:3]);
    assign win_w   = (r_ptr[7:3] == CTL_BASE[7:3]);
    assign do_wr   = acc && (i_action == ACT_WRITE_DATA) && !r_expect
                     && ({1'b0, r_ptr} < 9'(REGISTER_COUNT));

    assign p_hi = i_pressure_sample[SAMPLE_BITS-1:SAMPLE_BITS-8];
    assign p_lo = {i_pressure_sample[1:0], 6'b000000};

    assign ctl.setpoint  = r_ctl[CTL_SETPOINT];
    assign ctl.half_band = r_ctl[CTL_HALF_BAND];
    assign ctl.mode      = r_ctl[CTL_MODE];
    assign ctl.desired   = r_ctl[CTL_DESIRED];
    assign ctl.pressure  = p_hi;

    pbbr_valve u_valve (
        .i_ctl  (ctl),
        .i_cur  (r_valve),
        .o_next (valve_tick)
    );

    always_comb begin
        n_ptr    = r_ptr;
        n_expect = r_expect;
        n_valve  = r_valve;
        case (i_action)
            ACT_WRITE_ADDR: begin
                n_expect = 1'b1;
            end
            ACT_WRITE_DATA: begin
                if (r_expect) begin
                    n_ptr    = i_data_byte;
                    n_expect = 1'b0;
                end else if (do_wr) begin
                    n_ptr = (r_ptr == 8'hFF) ? r_ptr : r_ptr + 8'd1;
                end
            end
            ACT_READ_FIRST, ACT_READ_NEXT: begin
                n_ptr = (rp == 8'hFF) ? rp : rp + 8'd1;
            end
            ACT_TICK: begin
                n_valve = valve_tick;
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_comb begin
        n_s1_byte    = 8'h00;
        n_s1_sel_mem = 1'b0;
        if (is_rd && rd_rng) begin
            if (win_r) begin
                n_s1_byte = r_ctl[rp[2:0]];
            end else begin
                n_s1_byte    = def_entry(rp);
                n_s1_sel_mem = r_vld[rp[IW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= 8'h00;
            r_expect <= 1'b1;
            r_valve  <= '0;
            r_vld    <= '0;
            for (int k = 0; k < 8; k++) begin
                r_ctl[k] <= def_entry(CTL_BASE + 8'(k));
            end
        end else if (acc) begin
            r_ptr    <= n_ptr;
            r_expect <= n_expect;
            r_valve  <= n_valve;
            if (do_wr) begin
                r_vld[r_ptr[IW-1:0]] <= 1'b1;
                if (win_w) begin
                    r_ctl[r_ptr[2:0]] <= i_data_byte;
                end
            end
            if (is_tick) begin
                r_ctl[CTL_PRESS_HI] <= p_hi;
                r_ctl[CTL_PRESS_LO] <= p_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_ptr[IW-1:0]] <= i_data_byte;
        end
        if (acc) begin
            r_mem_q <= r_mem[rp[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_rv      <= is_rd;
            r_s1_sel_mem <= n_s1_sel_mem;
            r_s1_byte    <= n_s1_byte;
            r_s1_valve   <= n_valve;
        end
        if (s1_move && r_s1_valid) begin
            r_out_data  <= r_s1_sel_mem ? r_mem_q : r_s1_byte;
            r_out_rv    <= r_s1_rv;
            r_out_valve <= r_s1_valve;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_read_valid    = r_out_rv;
    assign o_release_valve = r_out_valve.release_drv;
    assign o_inflate_valve = r_out_valve.inflate_drv;
    assign o_valve_state   = r_out_valve.state;

endmodule

// File: src/pbbr_valve.sv
// Next valve state for one control tick, manual or three-state bang-bang with deadband.
// Depends on pbbr_pkg for the control codes and types.
module pbbr_valve (
    input  pbbr_pkg::t_ctl_in i_ctl,
    input  pbbr_pkg::t_valve  i_cur,
    output pbbr_pkg::t_valve  o_next
);
    import pbbr_pkg::*;

    logic [15:0] sp;
    logic [15:0] hb;
    logic [15:0] p;
    logic [15:0] top;
    logic [15:0] bottom;

    assign sp     = {8'h00, i_ctl.setpoint};
    assign hb     = {8'h00, i_ctl.half_band};
    assign p      = {8'h00, i_ctl.pressure};
    assign top    = sp + hb;
    assign bottom = sp - hb;

    always_comb begin
        o_next = i_cur;
        if (i_ctl.mode == MODE_AUTO) begin
            case (i_cur.state)
                ST_RELEASE: begin
                    o_next = drive((p < sp) ? ST_HOLD : ST_RELEASE);
                end
                ST_HOLD: begin
                    if (p > top) begin
                        o_next = drive(ST_RELEASE);
                    end else if (p < bottom) begin
                        o_next = drive(ST_INFLATE);
                    end else begin
                        o_next = drive(ST_HOLD);
                    end
                end
                ST_INFLATE: begin
                    o_next = drive((p > sp) ? ST_HOLD : ST_INFLATE);
                end
                default: begin
                    o_next = i_cur;
                end
            endcase
        end else if (i_ctl.mode == MODE_MANUAL) begin
            if (i_ctl.desired <= 8'(ST_INFLATE)) begin
                o_next = drive(i_ctl.desired[1:0]);
            end
        end
    end

endmodule
